### design/pux_pkg.sv
// shared widths, defaults and item codes for the profile x-drop extension block
package pux_pkg;

  // parameter defaults
  localparam int MAX_PROFILE_LEN_DEF = 1024;
  localparam int MAX_SUBJECT_LEN_DEF = 4096;
  localparam int ALPHABET_SIZE_DEF   = 32;
  localparam int SCORE_WIDTH_DEF     = 10;

  // item field widths
  localparam int FUNC_W   = 2;
  localparam int PP_W     = 11;
  localparam int SP_W     = 13;
  localparam int RES_W    = 5;
  localparam int VAL_W    = 10;
  localparam int BEST_W   = 24;
  localparam int XD_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  // packed stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // field offsets in the input tdata
  localparam int PP_LSB  = 0;
  localparam int SP_LSB  = PP_LSB + PP_W;
  localparam int RES_LSB = SP_LSB + SP_W;
  localparam int VAL_LSB = RES_LSB + RES_W;

  // reset values of the registers
  localparam logic [PP_W-1:0] PROFILE_LEN_RST = PP_W'(1024);
  localparam logic [SP_W-1:0] SUBJECT_LEN_RST = SP_W'(4096);
  localparam logic [XD_W-1:0] XDROP_LIMIT_RST = XD_W'(22);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_PROF  = 2'd0,
    FUNC_WR_TRANS = 2'd1,
    FUNC_WR_SUBJ  = 2'd2,
    FUNC_EXTEND   = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROFILE_LEN     = 2'd0,
    REG_SUBJECT_LEN     = 2'd1,
    REG_XDROP_LIMIT     = 2'd2,
    REG_USE_TRANSITIONS = 2'd3
  } reg_idx_t;

endpackage

### design/pux_ram.sv
// generic single-write, single-read ram with registered read data
module pux_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/profile_ungapped_xdrop_extend.sv
// ungapped x-drop extension of a seed pair against a position-specific profile
//
// usage: items arrive on the s_ stream; s_tuser selects the item kind. kinds
// 0, 1 and 2 write one profile score, one transition bonus or one subject
// residue into on-chip ram and return nothing. kind 3 extends a seed and
// returns one item on the m_ stream with the best score and subject bounds;
// m_tuser flags a seed outside the loaded lengths, with all data zero.
// the cfg_ port sets lengths, x-drop and transition mode between items.
// walk: a write item leaves the block idle, ready for the next item. each
// walked position of an extend is a subject read, then a dependent profile
// read, then the accumulate, all through the single read port of each ram.
// a bad seed goes from idle straight to the done state without a walk.
// one item is worked on at a time; s_tready is high while the block idles.
// the result sits in an output register, so a new item is accepted while
// a result waits; a finished extend waits for the register to empty when
// m_tready stays low.
// reset (synchronous rst) sets the registers to their defaults and empties
// the output; ram contents stay undefined until written.
module profile_ungapped_xdrop_extend #(
  parameter int MAX_PROFILE_LEN = pux_pkg::MAX_PROFILE_LEN_DEF,
  parameter int MAX_SUBJECT_LEN = pux_pkg::MAX_SUBJECT_LEN_DEF,
  parameter int ALPHABET_SIZE   = pux_pkg::ALPHABET_SIZE_DEF,
  parameter int SCORE_WIDTH     = pux_pkg::SCORE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // profile_pos, subject_pos, residue, value
  input  logic [pux_pkg::IN_TDATA_W-1:0]      s_tdata,
  // func
  input  logic [pux_pkg::FUNC_W-1:0]          s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // best_score, left_pos, right_pos, zero fill
  output logic [pux_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // seed_error
  output logic                                m_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_we,
  input  logic [pux_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pux_pkg::CFG_W-1:0]           cfg_wdata
);

  import pux_pkg::*;

  localparam int PA_W  = $clog2((MAX_PROFILE_LEN + 1) * ALPHABET_SIZE);
  localparam int TA_W  = $clog2(MAX_PROFILE_LEN + 1);
  localparam int SA_W  = $clog2(MAX_SUBJECT_LEN + 1);
  localparam int SUM_W = (SCORE_WIDTH + 14 > 25) ? SCORE_WIDTH + 14 : 25;
  localparam int SC_HI = 2 ** (SCORE_WIDTH - 1) - 1;
  localparam int SC_LO = -SC_HI - 1;
  localparam logic signed [SUM_W-1:0] BEST_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] BEST_MIN = SUM_W'(-8388608);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUBJ = 5'b00010,
    S_PROF = 5'b00100,
    S_ACC  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic logic [SCORE_WIDTH-1:0] clamp_score(input logic signed [VAL_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi > SC_HI) begin
      return SCORE_WIDTH'(SC_HI);
    end else if (vi < SC_LO) begin
      return SCORE_WIDTH'(SC_LO);
    end
    return SCORE_WIDTH'(vi);
  endfunction

  state_t state;

  // configuration
  logic [PP_W-1:0] profile_len;
  logic [SP_W-1:0] subject_len;
  logic [XD_W-1:0] xdrop_limit;
  logic            use_transitions;

  // input fields
  func_t                   in_func;
  logic [PP_W-1:0]         in_pp;
  logic [SP_W-1:0]         in_sp;
  logic [RES_W-1:0]        in_res;
  logic signed [VAL_W-1:0] in_val;
  logic                    in_acc;

  assign in_func = func_t'(s_tuser);
  assign in_pp   = s_tdata[PP_LSB +: PP_W];
  assign in_sp   = s_tdata[SP_LSB +: SP_W];
  assign in_res  = s_tdata[RES_LSB +: RES_W];
  assign in_val  = s_tdata[VAL_LSB +: VAL_W];
  assign in_acc  = s_tvalid && s_tready;

  // ram ports
  logic                   prof_we, trans_we, subj_we;
  logic [PA_W-1:0]        prof_waddr, prof_raddr;
  logic [TA_W-1:0]        trans_raddr;
  logic [SCORE_WIDTH-1:0] wr_score;
  logic [SCORE_WIDTH-1:0] prof_rdata, trans_rdata;
  logic [RES_W-1:0]       subj_rdata;
  logic                   rd_subj, rd_prof;

  // walk state
  logic [PP_W-1:0]         cur_pp, seed_pp, rem, bcnt;
  logic [SP_W-1:0]         cur_sp, seed_sp;
  logic                    fwd, first, err;
  logic signed [SUM_W-1:0] sum, best;
  logic [SP_W-1:0]         left, right;

  // output register
  logic [BEST_W-1:0] out_best;
  logic [SP_W-1:0]   out_left, out_right;
  logic              out_err;

  // seed check
  logic [PP_W-1:0] plen, pdiff, fwd_end, lim;
  logic [SP_W-1:0] slen, sdiff;
  logic            seed_bad;

  always_comb begin
    plen  = (32'(profile_len) < MAX_PROFILE_LEN) ? profile_len : PP_W'(MAX_PROFILE_LEN);
    slen  = (32'(subject_len) < MAX_SUBJECT_LEN) ? subject_len : SP_W'(MAX_SUBJECT_LEN);
    seed_bad = (in_pp >= plen) || (in_sp >= slen);
    pdiff = plen - in_pp;
    sdiff = slen - in_sp;
    fwd_end = (sdiff < SP_W'(pdiff)) ? PP_W'(sdiff) : pdiff;
    lim   = (SP_W'(in_pp) < in_sp) ? in_pp : PP_W'(in_sp);
  end

  // store writes
  assign wr_score   = clamp_score(in_val);
  assign prof_we    = in_acc && (in_func == FUNC_WR_PROF) && (32'(in_pp) <= MAX_PROFILE_LEN)
                      && (32'(in_res) < ALPHABET_SIZE);
  assign trans_we   = in_acc && (in_func == FUNC_WR_TRANS) && (32'(in_pp) <= MAX_PROFILE_LEN);
  assign subj_we    = in_acc && (in_func == FUNC_WR_SUBJ) && (32'(in_sp) <= MAX_SUBJECT_LEN)
                      && (32'(in_res) < ALPHABET_SIZE);
  assign prof_waddr = PA_W'(32'(in_pp) * ALPHABET_SIZE + 32'(in_res));

  // walk reads: subject and bonus first, then the profile entry that the subject residue selects
  assign rd_subj     = (state == S_SUBJ);
  assign rd_prof     = (state == S_PROF);
  assign trans_raddr = TA_W'(fwd ? cur_pp - PP_W'(1) : cur_pp);
  assign prof_raddr  = PA_W'(32'(cur_pp) * ALPHABET_SIZE + 32'(subj_rdata));

  pux_ram #(.WIDTH(SCORE_WIDTH), .DEPTH((MAX_PROFILE_LEN + 1) * ALPHABET_SIZE)) u_prof_ram (
    .clk   (clk),
    .we    (prof_we),
    .waddr (prof_waddr),
    .wdata (wr_score),
    .re    (rd_prof),
    .raddr (prof_raddr),
    .rdata (prof_rdata)
  );

  pux_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(MAX_PROFILE_LEN + 1)) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr (TA_W'(in_pp)),
    .wdata (wr_score),
    .re    (rd_subj),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  pux_ram #(.WIDTH(RES_W), .DEPTH(MAX_SUBJECT_LEN + 1)) u_subj_ram (
    .clk   (clk),
    .we    (subj_we),
    .waddr (SA_W'(in_sp)),
    .wdata (in_res),
    .re    (rd_subj),
    .raddr (SA_W'(cur_sp)),
    .rdata (subj_rdata)
  );

  // accumulate step
  logic signed [SCORE_WIDTH-1:0] prof_s, trans_s;
  logic signed [SUM_W-1:0]       step, s_new, best_new, diff, xd_s;
  logic                          better, stop, fwd_more, bwd_more;

  always_comb begin
    prof_s   = prof_rdata;
    trans_s  = trans_rdata;
    xd_s     = SUM_W'(xdrop_limit);
    step     = SUM_W'(prof_s) + ((use_transitions && !first) ? SUM_W'(trans_s) : '0);
    s_new    = first ? step : sum + step;
    better   = first || (s_new > best);
    best_new = better ? s_new : best;
    diff     = best - s_new;
    stop     = !better && ((diff >= xd_s) || s_new[SUM_W-1]);
    fwd_more = !stop && (rem > PP_W'(1));
    bwd_more = !stop && (bcnt > PP_W'(1));
  end

  logic out_load;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign s_tready = (state == S_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      profile_len     <= PROFILE_LEN_RST;
      subject_len     <= SUBJECT_LEN_RST;
      xdrop_limit     <= XDROP_LIMIT_RST;
      use_transitions <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_PROFILE_LEN:     profile_len     <= cfg_wdata[PP_W-1:0];
          REG_SUBJECT_LEN:     subject_len     <= cfg_wdata[SP_W-1:0];
          REG_XDROP_LIMIT:     xdrop_limit     <= cfg_wdata[XD_W-1:0];
          REG_USE_TRANSITIONS: use_transitions <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc && (in_func == FUNC_EXTEND)) begin
            state <= seed_bad ? S_DONE : S_SUBJ;
          end
        end
        S_SUBJ: state <= S_PROF;
        S_PROF: state <= S_ACC;
        S_ACC: begin
          if (fwd) begin
            state <= (fwd_more || (bcnt != '0)) ? S_SUBJ : S_DONE;
          end else begin
            state <= bwd_more ? S_SUBJ : S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          err     <= seed_bad;
          seed_pp <= in_pp;
          seed_sp <= in_sp;
          cur_pp  <= in_pp + PP_W'(1);
          cur_sp  <= in_sp + SP_W'(1);
          left    <= in_sp + SP_W'(1);
          right   <= in_sp + SP_W'(1);
          rem     <= fwd_end;
          bcnt    <= lim;
          fwd     <= 1'b1;
          first   <= 1'b1;
          sum     <= '0;
          best    <= '0;
        end
      end
      S_ACC: begin
        first <= 1'b0;
        best  <= best_new;
        if (fwd) begin
          if (better) begin
            right <= cur_sp;
          end
          if (fwd_more) begin
            sum    <= s_new;
            cur_pp <= cur_pp + PP_W'(1);
            cur_sp <= cur_sp + SP_W'(1);
            rem    <= rem - PP_W'(1);
          end else begin
            // backward walk restarts from the best forward sum at the seed
            sum    <= best_new;
            cur_pp <= seed_pp;
            cur_sp <= seed_sp;
            fwd    <= 1'b0;
          end
        end else begin
          if (better) begin
            left <= cur_sp;
          end
          sum    <= s_new;
          cur_pp <= cur_pp - PP_W'(1);
          cur_sp <= cur_sp - SP_W'(1);
          bcnt   <= bcnt - PP_W'(1);
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_err <= err;
      if (err) begin
        out_best  <= '0;
        out_left  <= '0;
        out_right <= '0;
      end else begin
        if (best > BEST_MAX) begin
          out_best <= BEST_MAX[BEST_W-1:0];
        end else if (best < BEST_MIN) begin
          out_best <= BEST_MIN[BEST_W-1:0];
        end else begin
          out_best <= best[BEST_W-1:0];
        end
        out_left  <= left;
        out_right <= right;
      end
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - BEST_W - 2 * SP_W){1'b0}}, out_right, out_left, out_best};
  assign m_tuser = out_err;

  // no read past the store depth while walking
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUBJ) |-> (32'(cur_pp) <= MAX_PROFILE_LEN) && (32'(cur_sp) <= MAX_SUBJECT_LEN))
    else $error("walk position beyond store depth");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("seed error item carries data");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (out_left <= out_right))
    else $error("left bound past right bound");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (prof_we || trans_we || subj_we) |-> (state == S_IDLE))
    else $error("store write during extension");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_load) |=> (state == S_DONE) && $stable(best))
    else $error("result lost while output stalled");

endmodule

### bench/tb_top.sv
// self-checking bench for the profile x-drop extension block
`timescale 1ns / 100ps

module tb_top;
  import pux_pkg::*;

  localparam int MAXP = MAX_PROFILE_LEN_DEF;
  localparam int MAXS = MAX_SUBJECT_LEN_DEF;
  localparam int ALPH = ALPHABET_SIZE_DEF;
  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 8;

  typedef struct packed {
    logic [BEST_W-1:0] best;
    logic [SP_W-1:0]   left;
    logic [SP_W-1:0]   right;
    logic              err;
  } ext_result_t;

  typedef struct packed {
    bit                       is_reg;
    reg_idx_t                 idx;
    logic [CFG_W-1:0]         regval;
    func_t                    f;
    logic [PP_W-1:0]          pp;
    logic [SP_W-1:0]          sp;
    logic [RES_W-1:0]         res;
    logic [VAL_W-1:0]         val;
    bit                       typed_err;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  // profile_pos, subject_pos, residue, value, zero fill
  logic [IN_TDATA_W-1:0]  s_tdata;
  // func
  logic [FUNC_W-1:0]      s_tuser;
  logic                   s_tvalid;
  logic                   s_tready;
  // best_score, left_pos, right_pos, zero fill
  logic [OUT_TDATA_W-1:0] m_tdata;
  // seed_error
  logic                   m_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_addr;
  logic [CFG_W-1:0]       cfg_wdata;

  profile_ungapped_xdrop_extend dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block's stores and registers
  logic signed [VAL_W-1:0] prof_mem [0:MAXP][0:ALPH-1];
  bit                      prof_ok  [0:MAXP][0:ALPH-1];
  logic signed [VAL_W-1:0] trans_mem [0:MAXP];
  bit                      trans_ok  [0:MAXP];
  logic [RES_W-1:0]        subj_mem [0:MAXS];
  bit                      subj_ok  [0:MAXS];
  logic [PP_W-1:0] cfg_plen  = PROFILE_LEN_RST;
  logic [SP_W-1:0] cfg_slen  = SUBJECT_LEN_RST;
  logic [XD_W-1:0] cfg_xd    = XDROP_LIMIT_RST;
  logic            cfg_trans = 1'b0;

  ext_result_t pending_extends [$];
  ext_result_t want_r;
  plan_row_t   plan [$];
  int mismatches = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  function automatic plan_row_t item_row(func_t f, int pp, int sp, int res, int val,
                                         bit typed_err);
    plan_row_t r;
    r = '0;
    r.f = f;
    r.pp = PP_W'(pp);
    r.sp = SP_W'(sp);
    r.res = RES_W'(res);
    r.val = VAL_W'(val);
    r.typed_err = typed_err;
    return r;
  endfunction

  function automatic plan_row_t reg_row(reg_idx_t idx, int v);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.regval = CFG_W'(v);
    return r;
  endfunction

  function automatic bit have_step(int pos, int spos, int tpos);
    if (!subj_ok[spos]) return 1'b0;
    if (!prof_ok[pos][subj_mem[spos]]) return 1'b0;
    return (tpos < 0) || trans_ok[tpos];
  endfunction

  function automatic longint step_gain(int pos, int spos, int tpos);
    longint g;
    g = longint'(prof_mem[pos][subj_mem[spos]]);
    if (cfg_trans && tpos >= 0) g += longint'(trans_mem[tpos]);
    return g;
  endfunction

  // scores mostly negative so walks end after a few dozen positions
  function automatic logic [VAL_W-1:0] fill_score();
    if ($urandom_range(0, 99) < 60) return VAL_W'(-int'($urandom_range(1, 512)));
    return VAL_W'($urandom_range(0, 511));
  endfunction

  // forward then backward x-drop walk; gap is set with the first step that
  // would read a store entry not yet written
  task automatic xdrop_walk(input int pp, input int sp, output ext_result_t r,
                            output bit gap, output int gpos, output int gspos,
                            output int gtpos);
    int plen, slen, fwd_end, lim, i, k, right, left;
    longint s, top, xd;
    bit stop;
    r = '0;
    gap = 1'b0;
    plen = (cfg_plen < MAXP) ? int'(cfg_plen) : MAXP;
    slen = (cfg_slen < MAXS) ? int'(cfg_slen) : MAXS;
    gpos = 0;
    gspos = 0;
    gtpos = -1;
    if (pp >= plen || sp >= slen) begin
      r.err = 1'b1;
      return;
    end
    xd = longint'(cfg_xd);
    fwd_end = ((slen - sp) < (plen - pp)) ? (slen - sp) : (plen - pp);
    gpos = pp + 1;
    gspos = sp + 1;
    if (!have_step(gpos, gspos, gtpos)) begin
      gap = 1'b1;
      return;
    end
    s = step_gain(gpos, gspos, gtpos);
    top = s;
    right = sp + 1;
    stop = 1'b0;
    for (i = 2; i <= fwd_end && !stop; i++) begin
      gpos = pp + i;
      gspos = sp + i;
      gtpos = pp + i - 1;
      if (!have_step(gpos, gspos, gtpos)) begin
        gap = 1'b1;
        return;
      end
      s += step_gain(gpos, gspos, gtpos);
      if (s > top) begin
        top = s;
        right = sp + i;
      end else if (s <= top - xd || s < 0) begin
        stop = 1'b1;
      end
    end
    lim = (pp < sp) ? pp : sp;
    left = sp + 1;
    s = top;
    stop = 1'b0;
    for (k = 0; k < lim && !stop; k++) begin
      gpos = pp - k;
      gspos = sp - k;
      gtpos = pp - k;
      if (!have_step(gpos, gspos, gtpos)) begin
        gap = 1'b1;
        return;
      end
      s += step_gain(gpos, gspos, gtpos);
      if (s > top) begin
        top = s;
        left = sp - k;
      end else if (s <= top - xd || s < 0) begin
        stop = 1'b1;
      end
    end
    if (top > 64'sd8388607) top = 64'sd8388607;
    if (top < -64'sd8388608) top = -64'sd8388608;
    r.best = top[BEST_W-1:0];
    r.left = SP_W'(left);
    r.right = SP_W'(right);
  endtask

  // updates the mirror, then offers the item until the block takes it
  task automatic put_item(func_t f, logic [PP_W-1:0] pp, logic [SP_W-1:0] sp,
                          logic [RES_W-1:0] res, logic [VAL_W-1:0] val);
    bit counted;
    counted = 1'b1;
    case (f)
      FUNC_WR_PROF: begin
        if (pp <= MAXP) begin
          prof_mem[pp][res] = val;
          prof_ok[pp][res] = 1'b1;
        end else counted = 1'b0;
      end
      FUNC_WR_TRANS: begin
        if (pp <= MAXP) begin
          trans_mem[pp] = val;
          trans_ok[pp] = 1'b1;
        end else counted = 1'b0;
      end
      FUNC_WR_SUBJ: begin
        if (sp <= MAXS) begin
          subj_mem[sp] = res;
          subj_ok[sp] = 1'b1;
        end else counted = 1'b0;
      end
      default: ;
    endcase
    if (counted) items_sent++;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {1'b0, val, res, sp, pp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic fill_gap(int gpos, int gspos, int gtpos);
    if (!subj_ok[gspos])
      put_item(FUNC_WR_SUBJ, PP_W'($urandom_range(0, 2047)), SP_W'(gspos),
               RES_W'($urandom_range(0, ALPH - 1)), VAL_W'($urandom_range(0, 1023)));
    else if (!prof_ok[gpos][subj_mem[gspos]])
      put_item(FUNC_WR_PROF, PP_W'(gpos), SP_W'($urandom_range(0, 8191)), subj_mem[gspos],
               fill_score());
    else
      put_item(FUNC_WR_TRANS, PP_W'(gtpos), SP_W'($urandom_range(0, 8191)),
               RES_W'($urandom_range(0, ALPH - 1)), fill_score());
  endtask

  task automatic run_extend(int pp, int sp, bit typed_err);
    ext_result_t r;
    bit gap;
    int gp, gs, gt;
    xdrop_walk(pp, sp, r, gap, gp, gs, gt);
    while (gap) begin
      fill_gap(gp, gs, gt);
      xdrop_walk(pp, sp, r, gap, gp, gs, gt);
    end
    if (typed_err) begin
      r = '0;
      r.err = 1'b1;
    end
    pending_extends.push_back(r);
    put_item(FUNC_EXTEND, PP_W'(pp), SP_W'(sp), RES_W'($urandom_range(0, ALPH - 1)),
             VAL_W'($urandom_range(0, 1023)));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_extends.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    case (idx)
      REG_PROFILE_LEN:     cfg_plen = v[PP_W-1:0];
      REG_SUBJECT_LEN:     cfg_slen = v[SP_W-1:0];
      REG_XDROP_LIMIT:     cfg_xd = v[XD_W-1:0];
      REG_USE_TRANSITIONS: cfg_trans = v[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_pos(int n);
    if (n > 64 && $urandom_range(0, 99) < 80) return $urandom_range(0, 63);
    return $urandom_range(0, n - 1);
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_extends.size() == 0) begin
        report("unexpected item", m_tdata[31:0], 32'd0);
      end else begin
        want_r = pending_extends.pop_front();
        if (m_tdata[23:0] !== want_r.best)
          report("best_score", 32'(m_tdata[23:0]), 32'(want_r.best));
        if (m_tdata[36:24] !== want_r.left)
          report("left_pos", 32'(m_tdata[36:24]), 32'(want_r.left));
        if (m_tdata[49:37] !== want_r.right)
          report("right_pos", 32'(m_tdata[49:37]), 32'(want_r.right));
        if (m_tuser !== want_r.err) report("seed_error", 32'(m_tuser), 32'(want_r.err));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph, base, target, plen, slen, dice;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_WR_PROF;
    cfg_we = 1'b0;
    cfg_addr = REG_PROFILE_LEN;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part; typed rows are seeds outside the loaded lengths
    plan.push_back(item_row(FUNC_EXTEND, 1024, 0, 0, 0, 1));
    plan.push_back(item_row(FUNC_EXTEND, 0, 4096, 31, 511, 1));
    plan.push_back(item_row(FUNC_EXTEND, 2047, 8191, 31, -512, 1));
    plan.push_back(item_row(FUNC_WR_PROF, 2047, 0, 31, -512, 0));
    plan.push_back(item_row(FUNC_WR_SUBJ, 0, 8191, 31, 511, 0));
    plan.push_back(item_row(FUNC_WR_TRANS, 1025, 0, 0, 511, 0));
    plan.push_back(item_row(FUNC_WR_SUBJ, 0, 4096, 31, 511, 0));
    plan.push_back(item_row(FUNC_WR_PROF, 1024, 0, 31, 511, 0));
    plan.push_back(item_row(FUNC_WR_TRANS, 1024, 8191, 0, -512, 0));
    plan.push_back(item_row(FUNC_WR_SUBJ, 5, 1, 0, 0, 0));
    plan.push_back(item_row(FUNC_WR_PROF, 1, 0, 0, -512, 0));
    plan.push_back(item_row(FUNC_EXTEND, 0, 0, 0, 0, 0));
    plan.push_back(item_row(FUNC_EXTEND, 1023, 4095, 0, 0, 0));
    plan.push_back(reg_row(REG_XDROP_LIMIT, 0));
    plan.push_back(item_row(FUNC_EXTEND, 5, 7, 0, 0, 0));
    plan.push_back(reg_row(REG_USE_TRANSITIONS, 1));
    plan.push_back(item_row(FUNC_EXTEND, 5, 7, 0, 0, 0));
    plan.push_back(reg_row(REG_XDROP_LIMIT, 65535));
    plan.push_back(item_row(FUNC_EXTEND, 10, 3, 0, 0, 0));
    plan.push_back(reg_row(REG_PROFILE_LEN, 0));
    plan.push_back(item_row(FUNC_EXTEND, 0, 0, 0, 0, 1));
    plan.push_back(reg_row(REG_PROFILE_LEN, 2047));
    plan.push_back(reg_row(REG_SUBJECT_LEN, 0));
    plan.push_back(item_row(FUNC_EXTEND, 0, 0, 0, 0, 1));
    plan.push_back(reg_row(REG_SUBJECT_LEN, 8191));
    plan.push_back(reg_row(REG_PROFILE_LEN, 1));
    plan.push_back(item_row(FUNC_EXTEND, 0, 10, 0, 0, 0));
    plan.push_back(item_row(FUNC_EXTEND, 1, 0, 0, 0, 1));

    foreach (plan[n]) begin
      if (plan[n].is_reg) begin
        wait_idle();
        write_reg(plan[n].idx, plan[n].regval);
      end else if (plan[n].f == FUNC_EXTEND) begin
        run_extend(int'(plan[n].pp), int'(plan[n].sp), plan[n].typed_err);
      end else begin
        put_item(plan[n].f, plan[n].pp, plan[n].sp, plan[n].res, plan[n].val);
      end
    end

    // random part, one register setting per phase
    for (ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_PROFILE_LEN, 16);
          write_reg(REG_SUBJECT_LEN, 40);
          write_reg(REG_XDROP_LIMIT, 22);
          write_reg(REG_USE_TRANSITIONS, 1);
        end
        1: begin
          write_reg(REG_PROFILE_LEN, 1024);
          write_reg(REG_SUBJECT_LEN, 4096);
          write_reg(REG_XDROP_LIMIT, 65535);
          write_reg(REG_USE_TRANSITIONS, 0);
        end
        2: begin
          write_reg(REG_PROFILE_LEN, 2047);
          write_reg(REG_SUBJECT_LEN, 8191);
          write_reg(REG_XDROP_LIMIT, 0);
          write_reg(REG_USE_TRANSITIONS, 1);
        end
        3: begin
          write_reg(REG_PROFILE_LEN, 1);
          write_reg(REG_SUBJECT_LEN, 1);
          write_reg(REG_XDROP_LIMIT, 100);
          write_reg(REG_USE_TRANSITIONS, 0);
        end
        4: begin
          write_reg(REG_PROFILE_LEN, 0);
          write_reg(REG_SUBJECT_LEN, 4096);
          write_reg(REG_XDROP_LIMIT, 22);
          write_reg(REG_USE_TRANSITIONS, 1);
        end
        5: begin
          write_reg(REG_PROFILE_LEN, CFG_W'($urandom_range(2, 200)));
          write_reg(REG_SUBJECT_LEN, CFG_W'($urandom_range(2, 300)));
          write_reg(REG_XDROP_LIMIT, CFG_W'($urandom_range(0, 400)));
          write_reg(REG_USE_TRANSITIONS, CFG_W'($urandom_range(0, 1)));
        end
        default: begin
          write_reg(REG_PROFILE_LEN, 64);
          write_reg(REG_SUBJECT_LEN, 64);
          write_reg(REG_XDROP_LIMIT, 35);
          write_reg(REG_USE_TRANSITIONS, 1);
        end
      endcase
      calm = (ph == 2);
      // result side stalls for a long stretch early in the first phase
      hold_off = (ph == 0);
      plen = (cfg_plen < MAXP) ? int'(cfg_plen) : MAXP;
      slen = (cfg_slen < MAXS) ? int'(cfg_slen) : MAXS;
      target = (ph == 4) ? 30 : 110;
      base = items_sent;
      while (items_sent - base < target) begin
        dice = $urandom_range(0, 99);
        if (dice < 12) begin
          put_item(func_t'($urandom_range(0, 2)), PP_W'($urandom_range(0, 2047)),
                   SP_W'($urandom_range(0, 8191)), RES_W'($urandom_range(0, ALPH - 1)),
                   VAL_W'($urandom_range(0, 1023)));
        end else if (dice < 22 || plen == 0 || slen == 0) begin
          if ($urandom_range(0, 1))
            run_extend($urandom_range(plen, 2047), $urandom_range(0, 8191), 0);
          else
            run_extend($urandom_range(0, 2047), $urandom_range(slen, 8191), 0);
        end else begin
          run_extend(pick_pos(plen), pick_pos(slen), 0);
        end
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
